@@ rtl/cfa_pkg.sv @@
// Shared types, codes and defaults of the contiguous fit allocator.
`timescale 1ns / 1ps
package cfa_pkg;

   localparam int MAX_SEGMENTS_DEF = 32;
   localparam int SIZE_BITS_DEF    = 16;

   localparam logic [1:0] FUNC_APPEND = 2'd0;
   localparam logic [1:0] FUNC_ALLOC  = 2'd1;
   localparam logic [1:0] FUNC_FREE   = 2'd2;

   localparam logic [1:0] MODE_FIRST = 2'd0;
   localparam logic [1:0] MODE_BEST  = 2'd1;
   localparam logic [1:0] MODE_WORST = 2'd2;
   localparam logic [1:0] MODE_NEXT  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   localparam logic [2:0] CMD_NONE     = 3'd0;
   localparam logic [2:0] CMD_ACCEPT   = 3'd1;
   localparam logic [2:0] CMD_SCAN     = 3'd2;
   localparam logic [2:0] CMD_DECIDE   = 3'd3;
   localparam logic [2:0] CMD_SHIFT_RD = 3'd4;
   localparam logic [2:0] CMD_SHIFT_WR = 3'd5;
   localparam logic [2:0] CMD_COMMIT   = 3'd6;
   localparam logic [2:0] CMD_COMMIT2  = 3'd7;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] req_size;
      logic [15:0] free_addr;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] alloc_addr;
   } rsp_type;

   typedef struct packed {
      logic [2:0] op;
   } cmd_type;

   typedef struct packed {
      logic early;
      logic scan_done;
      logic decide_fail;
      logic need_shift;
      logic shift_last;
      logic need_second;
   } stat_type;

endpackage

@@ rtl/contiguous_fit_allocator.sv @@
// Top level of the contiguous fit allocator: controller, datapath and checks.
`timescale 1ns / 1ps
// Usage:
//  - Request transaction: drive req_data and raise start; it is taken at the
//    clock edge where start is high and busy is low. func selects append,
//    allocate or free by address.
//  - Response transaction: rsp_data is valid for the single cycle rsp_strobe
//    is high. The receiver cannot stall; sample it in that cycle.
//  - Fit mode: csr_wr_en / csr_wr_data write the placement rule; write only
//    while busy is low.
//  - Sequence: append, unused func codes and allocates of size zero or on an
//    empty table go from accept straight to the response. Other requests scan
//    the table through the RAM read port, one segment per cycle, and decide;
//    a split or merge then moves the tail entries (one read, one write per
//    entry) before the commit and the response. One request is in flight.
//  - Reset (synchronous): the table is empty, the next fit pointer is at the
//    first segment and the mode is first fit. Table entries need no clearing;
//    only entries below the segment count are ever read.
module contiguous_fit_allocator
   import cfa_pkg::*;
#(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
   parameter int SIZE_BITS    = SIZE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_strobe,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer: one state per phase of a request
   cfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // table RAM, scan logic, split/merge and bookkeeping registers
   cfa_dp #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .SIZE_BITS    (SIZE_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .stat        (stat),
      .rsp_data    (rsp_data)
   );

`ifndef SYNTHESIS
   // accepted request always makes the block busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // response lasts exactly one cycle and ends the transaction
   a_strobe_once: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!rsp_strobe && !busy))
      else $error("response strobe not a single cycle");

   // refused requests report no address
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != ST_OK) |-> (rsp_data.alloc_addr == 16'd0))
      else $error("address on refused request");

   // strobe only while a transaction is in flight
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("response strobe while idle");
`endif

endmodule

@@ rtl/cfa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module cfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/cfa_ctrl.sv @@
// Sequencing state machine of the contiguous fit allocator.
`timescale 1ns / 1ps
module cfa_ctrl
   import cfa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy,
   output logic     rsp_strobe
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SCAN    = 3'd1;
   localparam logic [2:0] S_DECIDE  = 3'd2;
   localparam logic [2:0] S_SHRD    = 3'd3;
   localparam logic [2:0] S_SHWR    = 3'd4;
   localparam logic [2:0] S_COMMIT  = 3'd5;
   localparam logic [2:0] S_COMMIT2 = 3'd6;
   localparam logic [2:0] S_RESP    = 3'd7;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = CMD_NONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = CMD_ACCEPT;
               state_in = stat.early ? S_RESP : S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.op = CMD_SCAN;
            if (stat.scan_done) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.op = CMD_DECIDE;
            if (stat.decide_fail)     state_in = S_RESP;
            else if (stat.need_shift) state_in = S_SHRD;
            else                      state_in = S_COMMIT;
         end
         S_SHRD: begin
            cmd.op   = CMD_SHIFT_RD;
            state_in = S_SHWR;
         end
         S_SHWR: begin
            cmd.op   = CMD_SHIFT_WR;
            state_in = stat.shift_last ? S_COMMIT : S_SHRD;
         end
         S_COMMIT: begin
            cmd.op   = CMD_COMMIT;
            state_in = stat.need_second ? S_COMMIT2 : S_RESP;
         end
         S_COMMIT2: begin
            cmd.op   = CMD_COMMIT2;
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_RESP);

endmodule

@@ rtl/cfa_dp.sv @@
// Datapath of the contiguous fit allocator: segment table, scan, shift and commit.
`timescale 1ns / 1ps
module cfa_dp
   import cfa_pkg::*;
#(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
   parameter int SIZE_BITS    = SIZE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  req_type    req_data,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data,
   output stat_type   stat,
   output rsp_type    rsp_data
);

   localparam int SB   = SIZE_BITS;
   localparam int SZW  = SB + 1;
   localparam int IDXW = $clog2(MAX_SEGMENTS);
   localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
   localparam int RW   = SZW + 1;
   localparam logic [CNTW-1:0] MAXC = CNTW'(MAX_SEGMENTS);
   localparam logic [SB+1:0]   SPAN = (SB + 2)'(1) << SB;

   // RAM word: {free, size}
   logic            ram_we, ram_re;
   logic [IDXW-1:0] ram_waddr, ram_raddr;
   logic [RW-1:0]   ram_wdata, ram_rdata;

   cfa_ram #(.WIDTH(RW), .DEPTH(MAX_SEGMENTS)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   logic [1:0]      fit_mode_ff, fit_mode_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic [SZW-1:0]  total_ff, total_in;
   logic [IDXW-1:0] nf_ff, nf_in;
   logic [1:0]      func_ff, func_in;
   logic [SB-1:0]   size_ff, size_in;
   logic [SB-1:0]   faddr_ff, faddr_in;
   logic [CNTW-1:0] rd_idx_ff, rd_idx_in;
   logic            eval_valid_ff, eval_valid_in;
   logic [IDXW-1:0] eval_idx_ff, eval_idx_in;
   logic [SZW-1:0]  acc_ff, acc_in;
   logic            found_ff, found_in;
   logic            found_ge_ff, found_ge_in;
   logic [IDXW-1:0] sel_ff, sel_in;
   logic [SZW-1:0]  sel_size_ff, sel_size_in;
   logic [SB-1:0]   sel_start_ff, sel_start_in;
   logic [SZW-1:0]  last_sz_ff, last_sz_in;
   logic            last_fr_ff, last_fr_in;
   logic [SZW-1:0]  prev_sz_ff, prev_sz_in;
   logic            prev_fr_ff, prev_fr_in;
   logic            nx_seen_ff, nx_seen_in;
   logic [SZW-1:0]  nx_sz_ff, nx_sz_in;
   logic            nx_fr_ff, nx_fr_in;
   logic [IDXW-1:0] w_ff, w_in;
   logic [1:0]      nrem_ff, nrem_in;
   logic [SZW-1:0]  merged_ff, merged_in;
   logic [IDXW-1:0] j_ff, j_in;
   logic            split_ff, split_in;
   logic [1:0]      st_ff, st_in;
   logic [SB-1:0]   addr_ff, addr_in;

   logic [SB-1:0]   in_size;
   logic [SB+1:0]   append_sum;
   logic [1:0]      append_st;
   logic            early;
   logic            issue;
   logic            ev_fr;
   logic [SZW-1:0]  ev_sz;
   logic [IDXW-1:0] begin_idx;
   logic            elig, take, match;
   logic [CNTW-1:0] sel_p1;
   logic            split_c, pv, nx;
   logic [IDXW-1:0] w_c;
   logic [1:0]      nrem_c;
   logic [SZW-1:0]  merged_c;
   logic [CNTW-1:0] down_start;
   logic            d_fail, d_shift;
   logic [1:0]      d_st;
   logic [CNTW-1:0] nf_w, w_w, wr_w;

   assign in_size    = SB'(req_data.req_size);
   assign append_sum = (SB + 2)'(total_ff) + (SB + 2)'(in_size);

   always_comb begin
      if (in_size == '0)         append_st = ST_NOFIT;
      else if (count_ff >= MAXC) append_st = ST_FULL;
      else if (append_sum > SPAN) append_st = ST_RANGE;
      else                       append_st = ST_OK;
   end

   assign early = (req_data.func == FUNC_APPEND) ||
                  (req_data.func == FUNC_ALLOC && (in_size == '0 || count_ff == '0)) ||
                  (req_data.func != FUNC_ALLOC && req_data.func != FUNC_FREE);

   // scan
   assign issue     = (rd_idx_ff < count_ff);
   assign ev_fr     = ram_rdata[SZW];
   assign ev_sz     = ram_rdata[SZW-1:0];
   assign begin_idx = (CNTW'(nf_ff) < count_ff) ? nf_ff : '0;
   assign elig      = ev_fr && (ev_sz >= SZW'(size_ff));
   assign match     = !found_ff && (acc_ff == SZW'(faddr_ff));

   always_comb begin
      case (fit_mode_ff)
         MODE_FIRST: take = elig && !found_ff;
         MODE_BEST:  take = elig && (!found_ff || ev_sz < sel_size_ff);
         MODE_WORST: take = elig && (!found_ff || ev_sz > sel_size_ff);
         MODE_NEXT:  take = elig && (!found_ff ||
                            (eval_idx_ff >= begin_idx && !found_ge_ff));
         default:    take = 1'b0;
      endcase
   end

   // decide
   assign sel_p1     = CNTW'(sel_ff) + CNTW'(1);
   assign split_c    = (sel_size_ff != SZW'(size_ff));
   assign pv         = (sel_ff != '0) && prev_fr_ff;
   assign nx         = nx_seen_ff && nx_fr_ff;
   assign w_c        = pv ? sel_ff - IDXW'(1) : sel_ff;
   assign nrem_c     = {1'b0, pv} + {1'b0, nx};
   assign merged_c   = sel_size_ff + (pv ? prev_sz_ff : '0) + (nx ? nx_sz_ff : '0);
   assign down_start = CNTW'(w_c) + CNTW'(1) + CNTW'(nrem_c);

   always_comb begin
      if (func_ff == FUNC_ALLOC) begin
         d_fail  = !found_ff || (split_c && count_ff >= MAXC);
         d_st    = !found_ff ? ST_NOFIT : ST_FULL;
         d_shift = split_c && (count_ff > sel_p1);
      end else begin
         d_fail  = !found_ff;
         d_st    = ST_NOFIT;
         d_shift = (nrem_c != 2'd0) && (down_start < count_ff);
      end
   end

   assign nf_w = CNTW'(nf_ff);
   assign w_w  = CNTW'(w_ff);
   assign wr_w = w_w + CNTW'(nrem_ff);

   always_comb begin
      fit_mode_in   = fit_mode_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      nf_in         = nf_ff;
      func_in       = func_ff;
      size_in       = size_ff;
      faddr_in      = faddr_ff;
      rd_idx_in     = rd_idx_ff;
      eval_valid_in = 1'b0;
      eval_idx_in   = eval_idx_ff;
      acc_in        = acc_ff;
      found_in      = found_ff;
      found_ge_in   = found_ge_ff;
      sel_in        = sel_ff;
      sel_size_in   = sel_size_ff;
      sel_start_in  = sel_start_ff;
      last_sz_in    = last_sz_ff;
      last_fr_in    = last_fr_ff;
      prev_sz_in    = prev_sz_ff;
      prev_fr_in    = prev_fr_ff;
      nx_seen_in    = nx_seen_ff;
      nx_sz_in      = nx_sz_ff;
      nx_fr_in      = nx_fr_ff;
      w_in          = w_ff;
      nrem_in       = nrem_ff;
      merged_in     = merged_ff;
      j_in          = j_ff;
      split_in      = split_ff;
      st_in         = st_ff;
      addr_in       = addr_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_re        = 1'b0;
      ram_raddr     = rd_idx_ff[IDXW-1:0];

      if (csr_wr_en) fit_mode_in = csr_wr_data;

      case (cmd.op)
         CMD_ACCEPT: begin
            func_in     = req_data.func;
            size_in     = in_size;
            faddr_in    = SB'(req_data.free_addr);
            rd_idx_in   = '0;
            acc_in      = '0;
            found_in    = 1'b0;
            found_ge_in = 1'b0;
            nx_seen_in  = 1'b0;
            last_fr_in  = 1'b0;
            split_in    = 1'b0;
            addr_in     = '0;
            st_in       = ST_NOFIT;
            if (req_data.func == FUNC_APPEND) begin
               st_in = append_st;
               if (append_st == ST_OK) begin
                  ram_we    = 1'b1;
                  ram_waddr = count_ff[IDXW-1:0];
                  ram_wdata = {1'b1, SZW'(in_size)};
                  count_in  = count_ff + CNTW'(1);
                  total_in  = append_sum[SZW-1:0];
               end
            end
         end
         CMD_SCAN: begin
            if (issue) begin
               ram_re        = 1'b1;
               rd_idx_in     = rd_idx_ff + CNTW'(1);
               eval_valid_in = 1'b1;
               eval_idx_in   = rd_idx_ff[IDXW-1:0];
            end
            if (eval_valid_ff) begin
               acc_in     = acc_ff + ev_sz;
               last_sz_in = ev_sz;
               last_fr_in = ev_fr;
               if (func_ff == FUNC_ALLOC) begin
                  if (take) begin
                     found_in     = 1'b1;
                     sel_in       = eval_idx_ff;
                     sel_size_in  = ev_sz;
                     sel_start_in = acc_ff[SB-1:0];
                     if (eval_idx_ff >= begin_idx) found_ge_in = 1'b1;
                  end
               end else begin
                  if (match) begin
                     found_in    = 1'b1;
                     sel_in      = eval_idx_ff;
                     sel_size_in = ev_sz;
                     prev_sz_in  = last_sz_ff;
                     prev_fr_in  = last_fr_ff;
                  end else if (found_ff && !nx_seen_ff) begin
                     nx_seen_in = 1'b1;
                     nx_sz_in   = ev_sz;
                     nx_fr_in   = ev_fr;
                  end
               end
            end
         end
         CMD_DECIDE: begin
            st_in     = d_fail ? d_st : ST_OK;
            w_in      = w_c;
            nrem_in   = nrem_c;
            merged_in = merged_c;
            split_in  = (func_ff == FUNC_ALLOC) && split_c;
            if (func_ff == FUNC_ALLOC) j_in = IDXW'(count_ff - CNTW'(1));
            else                       j_in = IDXW'(down_start);
         end
         CMD_SHIFT_RD: begin
            ram_re    = 1'b1;
            ram_raddr = j_ff;
         end
         CMD_SHIFT_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            if (func_ff == FUNC_ALLOC) begin
               ram_waddr = j_ff + IDXW'(1);
               j_in      = j_ff - IDXW'(1);
            end else begin
               ram_waddr = j_ff - IDXW'(nrem_ff);
               j_in      = j_ff + IDXW'(1);
            end
         end
         CMD_COMMIT: begin
            ram_we = 1'b1;
            if (func_ff == FUNC_ALLOC) begin
               addr_in = sel_start_ff;
               if (split_ff) begin
                  ram_waddr = IDXW'(sel_p1);
                  ram_wdata = {1'b1, sel_size_ff - SZW'(size_ff)};
                  count_in  = count_ff + CNTW'(1);
                  if (nf_w >= sel_p1 && nf_w < count_ff) nf_in = nf_ff + IDXW'(1);
                  if (fit_mode_ff == MODE_NEXT)
                     nf_in = (sel_p1 < count_ff + CNTW'(1)) ? IDXW'(sel_p1) : '0;
               end else begin
                  ram_waddr = sel_ff;
                  ram_wdata = {1'b0, SZW'(size_ff)};
                  if (fit_mode_ff == MODE_NEXT)
                     nf_in = (sel_p1 < count_ff) ? IDXW'(sel_p1) : '0;
               end
            end else begin
               ram_waddr = w_ff;
               ram_wdata = {1'b1, merged_ff};
               count_in  = count_ff - CNTW'(nrem_ff);
               if (nf_w > w_w && nf_w <= wr_w) nf_in = w_ff;
               else if (nf_w > wr_w)           nf_in = nf_ff - IDXW'(nrem_ff);
            end
         end
         CMD_COMMIT2: begin
            ram_we    = 1'b1;
            ram_waddr = sel_ff;
            ram_wdata = {1'b0, SZW'(size_ff)};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff   <= MODE_FIRST;
         count_ff      <= '0;
         total_ff      <= '0;
         nf_ff         <= '0;
         eval_valid_ff <= 1'b0;
      end else begin
         fit_mode_ff   <= fit_mode_in;
         count_ff      <= count_in;
         total_ff      <= total_in;
         nf_ff         <= nf_in;
         eval_valid_ff <= eval_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      size_ff      <= size_in;
      faddr_ff     <= faddr_in;
      rd_idx_ff    <= rd_idx_in;
      eval_idx_ff  <= eval_idx_in;
      acc_ff       <= acc_in;
      found_ff     <= found_in;
      found_ge_ff  <= found_ge_in;
      sel_ff       <= sel_in;
      sel_size_ff  <= sel_size_in;
      sel_start_ff <= sel_start_in;
      last_sz_ff   <= last_sz_in;
      last_fr_ff   <= last_fr_in;
      prev_sz_ff   <= prev_sz_in;
      prev_fr_ff   <= prev_fr_in;
      nx_seen_ff   <= nx_seen_in;
      nx_sz_ff     <= nx_sz_in;
      nx_fr_ff     <= nx_fr_in;
      w_ff         <= w_in;
      nrem_ff      <= nrem_in;
      merged_ff    <= merged_in;
      j_ff         <= j_in;
      split_ff     <= split_in;
      st_ff        <= st_in;
      addr_ff      <= addr_in;
   end

   assign stat.early       = early;
   assign stat.scan_done   = !issue && !eval_valid_ff;
   assign stat.decide_fail = d_fail;
   assign stat.need_shift  = d_shift;
   assign stat.shift_last  = (func_ff == FUNC_ALLOC) ? (CNTW'(j_ff) == sel_p1)
                                                    : (CNTW'(j_ff) == count_ff - CNTW'(1));
   assign stat.need_second = split_ff;

   assign rsp_data.status     = st_ff;
   assign rsp_data.alloc_addr = (st_ff == ST_OK) ? 16'(addr_ff) : 16'd0;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the contiguous fit allocator.
`timescale 1ns / 1ps
module tb_top;
   import cfa_pkg::*;

   localparam int NSEG = 32;
   localparam int N_RANDOM = 550;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_data;
   logic       rsp_strobe;
   rsp_type    rsp_data;
   logic       csr_wr_en;
   logic [1:0] csr_wr_data;

   contiguous_fit_allocator u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // Shadow of the segment table, kept in step with the block.
   logic [16:0] seg_len [NSEG];
   logic        seg_avail [NSEG];
   int          seg_cnt;
   int          nf_ptr;
   logic [16:0] span_used;
   logic [1:0]  placement;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      mismatches;
   int      accepted;
   bit      hold_send;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

   function automatic int start_of(input int idx);
      int a;
      a = 0;
      for (int i = 0; i < idx; i++) a += seg_len[i];
      return a;
   endfunction

   // Drop entry idx, already merged into entry keep.
   function automatic void drop_seg(input int idx, input int keep);
      for (int i = idx; i + 1 < seg_cnt; i++) begin
         seg_len[i]   = seg_len[i+1];
         seg_avail[i] = seg_avail[i+1];
      end
      seg_cnt--;
      if (nf_ptr == idx) nf_ptr = keep;
      else if (nf_ptr > idx) nf_ptr--;
   endfunction

   function automatic void split_in(input int idx, input logic [16:0] len);
      for (int i = seg_cnt; i > idx; i--) begin
         seg_len[i]   = seg_len[i-1];
         seg_avail[i] = seg_avail[i-1];
      end
      seg_len[idx]   = len;
      seg_avail[idx] = 1'b1;
      seg_cnt++;
      if (nf_ptr >= idx && nf_ptr < seg_cnt - 1) nf_ptr++;
   endfunction

   // Computes the response of one request and updates the shadow table.
   function automatic rsp_type allocator_step(input req_type r);
      rsp_type     o;
      logic [16:0] sz;
      int          sel, cur, from, a, i;
      bit          found;
      logic [16:0] pick;
      o.status = ST_NOFIT;
      o.alloc_addr = '0;
      sz = {1'b0, r.req_size};
      found = 0;
      sel = 0;
      pick = '0;
      if (r.func == FUNC_APPEND) begin
         if (sz == 0) o.status = ST_NOFIT;
         else if (seg_cnt >= NSEG) o.status = ST_FULL;
         else if (span_used + sz > 17'h10000) o.status = ST_RANGE;
         else begin
            seg_len[seg_cnt] = sz;
            seg_avail[seg_cnt] = 1'b1;
            seg_cnt++;
            span_used += sz;
            o.status = ST_OK;
         end
      end else if (r.func == FUNC_ALLOC) begin
         if (sz != 0 && seg_cnt != 0) begin
            if (placement == MODE_NEXT) begin
               from = (nf_ptr < seg_cnt) ? nf_ptr : 0;
               for (i = 0; i < seg_cnt && !found; i++) begin
                  cur = (from + i) % seg_cnt;
                  if (seg_avail[cur] && seg_len[cur] >= sz) begin
                     sel = cur;
                     found = 1;
                  end
               end
            end else begin
               for (i = 0; i < seg_cnt; i++) begin
                  if (!(seg_avail[i] && seg_len[i] >= sz)) continue;
                  if (placement == MODE_FIRST) begin
                     if (!found) sel = i;
                     found = 1;
                  end else if (!found ||
                               (placement == MODE_BEST && seg_len[i] < pick) ||
                               (placement == MODE_WORST && seg_len[i] > pick)) begin
                     sel = i;
                     pick = seg_len[i];
                     found = 1;
                  end
               end
            end
            if (found) begin
               if (seg_len[sel] != sz && seg_cnt >= NSEG) o.status = ST_FULL;
               else begin
                  if (seg_len[sel] != sz) begin
                     split_in(sel + 1, seg_len[sel] - sz);
                     seg_len[sel] = sz;
                  end
                  seg_avail[sel] = 1'b0;
                  o.status = ST_OK;
                  o.alloc_addr = 16'(start_of(sel));
                  if (placement == MODE_NEXT) nf_ptr = (sel + 1 < seg_cnt) ? sel + 1 : 0;
               end
            end
         end
      end else if (r.func == FUNC_FREE) begin
         a = 0;
         for (i = 0; i < seg_cnt; i++) begin
            if (a == r.free_addr) break;
            a += seg_len[i];
         end
         if (i < seg_cnt) begin
            o.status = ST_OK;
            seg_avail[i] = 1'b1;
            if (i + 1 < seg_cnt && seg_avail[i+1]) begin
               seg_len[i] += seg_len[i+1];
               drop_seg(i + 1, i);
            end
            if (i > 0 && seg_avail[i-1]) begin
               seg_len[i-1] += seg_len[i];
               drop_seg(i, i - 1);
            end
         end
      end
      return o;
   endfunction

   // Driver: bursts with random gaps; inputs change on the falling edge.
   // start is raised only while the block is idle, so it is always taken
   // at the next rising edge.
   int gap_left, burst_left;
   always @(negedge clock) begin
      if (reset || busy || pending_reqs.size() == 0 || hold_send) begin
         start <= 1'b0;
      end else if (gap_left > 0) begin
         gap_left--;
         start <= 1'b0;
      end else begin
         req_data <= pending_reqs[0];
         start <= 1'b1;
         if (burst_left > 0) burst_left--;
         else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         end
      end
   end

   // Predictor: an accepted transaction leaves the queue and yields one expectation.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         expected_rsps.push_back(allocator_step(req_data));
         void'(pending_reqs.pop_front());
         accepted++;
      end
   end

   // Monitor: one response per strobe, compared against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", rsp_data);
         end else begin
            rsp_type e;
            e = expected_rsps.pop_front();
            if (e.status !== rsp_data.status || e.alloc_addr !== rsp_data.alloc_addr) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected status %0d addr %0h, got status %0d addr %0h",
                           e.status, e.alloc_addr, rsp_data.status, rsp_data.alloc_addr);
            end
         end
      end
   end

   function automatic req_type make_req(input logic [1:0] f, input logic [15:0] s,
                                        input logic [15:0] a);
      req_type r;
      r.func = f;
      r.req_size = s;
      r.free_addr = a;
      return r;
   endfunction

   // Free address: usually the start of a live segment, sometimes noise.
   function automatic logic [15:0] pick_free_addr();
      if (seg_cnt > 0 && $urandom_range(0, 7) != 0)
         return 16'(start_of($urandom_range(0, seg_cnt - 1)));
      return 16'($urandom);
   endfunction

   task automatic drain();
      wait (pending_reqs.size() == 0 && !start);
      wait (expected_rsps.size() == 0 && !busy);
      repeat (120) @(posedge clock);
   endtask

   task automatic set_mode(input logic [1:0] m);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      placement = m;
   endtask

   initial begin
      logic [1:0]  f;
      logic [15:0] s;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      seg_cnt = 0;
      nf_ptr = 0;
      span_used = '0;
      placement = MODE_FIRST;
      mismatches = 0;
      accepted = 0;
      hold_send = 0;
      gap_left = 0;
      burst_left = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty table, zero sizes, range limit, split and merge.
      pending_reqs.push_back(make_req(FUNC_ALLOC, 16'd5, 16'd0));
      pending_reqs.push_back(make_req(FUNC_APPEND, 16'd0, 16'd0));
      pending_reqs.push_back(make_req(FUNC_APPEND, 16'hFFFF, 16'hFFFF));
      pending_reqs.push_back(make_req(FUNC_APPEND, 16'd1, 16'd0));
      pending_reqs.push_back(make_req(FUNC_APPEND, 16'd1, 16'd0));
      pending_reqs.push_back(make_req(FUNC_ALLOC, 16'd0, 16'd0));
      pending_reqs.push_back(make_req(FUNC_ALLOC, 16'h8000, 16'd0));
      pending_reqs.push_back(make_req(FUNC_ALLOC, 16'h7FFF, 16'd0));
      pending_reqs.push_back(make_req(FUNC_FREE, 16'd0, 16'h1234));
      pending_reqs.push_back(make_req(FUNC_FREE, 16'd0, 16'h8000));
      pending_reqs.push_back(make_req(FUNC_FREE, 16'd0, 16'h8000));
      pending_reqs.push_back(make_req(FUNC_FREE, 16'd0, 16'd0));
      pending_reqs.push_back(make_req(2'd3, 16'hFFFF, 16'h0000));
      pending_reqs.push_back(make_req(FUNC_ALLOC, 16'hFFFF, 16'd0));
      pending_reqs.push_back(make_req(FUNC_FREE, 16'd0, 16'd0));
      drain();

      // Random phases: each mode in turn, table built up from small pieces.
      for (int ph = 0; ph < 8; ph++) begin
         set_mode(ph % 4 == 0 ? MODE_FIRST : ph % 4 == 1 ? MODE_BEST :
                  ph % 4 == 2 ? MODE_WORST : MODE_NEXT);
         for (int k = 0; k < N_RANDOM / 8; k++) begin
            f = ($urandom_range(0, 2) == 0) ? FUNC_APPEND :
                ($urandom_range(0, 1) == 0) ? FUNC_ALLOC : FUNC_FREE;
            if ($urandom_range(0, 30) == 0) f = 2'd3;
            case ($urandom_range(0, 9))
               0:       s = 16'($urandom);
               1:       s = 16'd0;
               2:       s = 16'hFFFF;
               default: s = 16'($urandom_range(1, 300));
            endcase
            if (f == FUNC_FREE) begin
               // Wait so the shadow table reflects all earlier requests.
               wait (pending_reqs.size() == 0 && !start);
               pending_reqs.push_back(make_req(f, 16'($urandom), pick_free_addr()));
            end else begin
               pending_reqs.push_back(make_req(f, s, 16'($urandom)));
            end
         end
         // Quiet spell: sender held until every response is in.
         if (ph == 3) begin
            hold_send = 1;
            wait (expected_rsps.size() == 0 && !busy);
            repeat (20) @(posedge clock);
            hold_send = 0;
         end
         drain();
      end

      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/cfa_pkg.sv
rtl/cfa_ram.sv
rtl/cfa_ctrl.sv
rtl/cfa_dp.sv
rtl/contiguous_fit_allocator.sv
tb/tb_top.sv
